[rtl/core/bpsd_pkg.sv]
// Shared types, register indexes, codes and reset values for the button sequence detector.
`default_nettype none

package bpsd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BURST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_BURST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PRESS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEXT_PRESS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_QUIET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL_QUIET  = 3'd6;

	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned PRESS_W    = 8;
	localparam int unsigned WIN_W      = 16;

	// Register reset values
	localparam logic [PRESS_W-1:0] RST_FIRST_BURST  = 8'd5;
	localparam logic [PRESS_W-1:0] RST_SECOND_BURST = 8'd6;
	localparam logic [WIN_W-1:0]   RST_RELEASE_WIN  = 16'd300;
	localparam logic [WIN_W-1:0]   RST_FIRST_PRESS  = 16'd200;
	localparam logic [WIN_W-1:0]   RST_NEXT_PRESS   = 16'd70;
	localparam logic [WIN_W-1:0]   RST_FIRST_QUIET  = 16'd100;
	localparam logic [WIN_W-1:0]   RST_FINAL_QUIET  = 16'd200;

	typedef struct packed {
		logic [PRESS_W-1:0] first_burst_presses;
		logic [PRESS_W-1:0] second_burst_presses;
		logic [WIN_W-1:0]   release_window;
		logic [WIN_W-1:0]   first_press_window;
		logic [WIN_W-1:0]   next_press_window;
		logic [WIN_W-1:0]   first_quiet_window;
		logic [WIN_W-1:0]   final_quiet_window;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_PASS  = 2'd1,
		ST_FAIL  = 2'd2,
		ST_NOARM = 2'd3
	} status_t;

	localparam logic [1:0] PROG_NONE = 2'd0;
	localparam logic [1:0] PROG_ONE  = 2'd1;
	localparam logic [1:0] PROG_TWO  = 2'd2;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_RELEASE = 6'b000010,
		PH_BURST1  = 6'b000100,
		PH_QUIET1  = 6'b001000,
		PH_BURST2  = 6'b010000,
		PH_QUIET2  = 6'b100000
	} phase_t;

endpackage

`default_nettype wire

[rtl/core/bpsd_cfg_regs.sv]
// Configuration register file of the button sequence detector.
`default_nettype none

module bpsd_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bpsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bpsd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bpsd_pkg::cfg_t                         cfg
);
	import bpsd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_burst_presses  <= RST_FIRST_BURST;
			cfg_q.second_burst_presses <= RST_SECOND_BURST;
			cfg_q.release_window       <= RST_RELEASE_WIN;
			cfg_q.first_press_window   <= RST_FIRST_PRESS;
			cfg_q.next_press_window    <= RST_NEXT_PRESS;
			cfg_q.first_quiet_window   <= RST_FIRST_QUIET;
			cfg_q.final_quiet_window   <= RST_FINAL_QUIET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_BURST:  cfg_q.first_burst_presses  <= cfg_data[PRESS_W-1:0];
				CFG_SECOND_BURST: cfg_q.second_burst_presses <= cfg_data[PRESS_W-1:0];
				CFG_RELEASE_WIN:  cfg_q.release_window       <= cfg_data[WIN_W-1:0];
				CFG_FIRST_PRESS:  cfg_q.first_press_window   <= cfg_data[WIN_W-1:0];
				CFG_NEXT_PRESS:   cfg_q.next_press_window    <= cfg_data[WIN_W-1:0];
				CFG_FIRST_QUIET:  cfg_q.first_quiet_window   <= cfg_data[WIN_W-1:0];
				CFG_FINAL_QUIET:  cfg_q.final_quiet_window   <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/bpsd_seq.sv]
// Sequence state and one-tick next-state and result logic.
`default_nettype none

module bpsd_seq #(
	parameter int unsigned TIMER_BITS = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic           start_req,
	input  wire logic           button_level,
	input  wire bpsd_pkg::cfg_t cfg,
	output bpsd_pkg::status_t   status,
	output logic [1:0]          progress
);
	import bpsd_pkg::*;

	localparam int unsigned CMP_W = (TIMER_BITS > WIN_W) ? TIMER_BITS : WIN_W;
	localparam int unsigned CNT_CMP_W = (COUNT_BITS + 1 > PRESS_W) ? COUNT_BITS + 1 : PRESS_W;

	phase_t                phase_q, phase_d;
	logic                  wfr_q, wfr_d;
	logic [COUNT_BITS-1:0] pd_q, pd_d;
	logic [TIMER_BITS-1:0] wt_q, wt_d;

	logic                  pressed;
	logic [TIMER_BITS-1:0] wt_inc;
	logic [WIN_W-1:0]      win_sel;
	logic [WIN_W-1:0]      win_lim;
	logic                  expired;
	logic [PRESS_W-1:0]    need;
	logic [PRESS_W-1:0]    need_lim;
	logic                  burst_done;
	logic                  match;

	assign pressed = ~button_level;

	// One saturating timer and one window compare serve whichever wait is active
	assign wt_inc = (wt_q == {TIMER_BITS{1'b1}}) ? wt_q : wt_q + 1'b1;

	always_comb begin
		unique case (phase_q)
			PH_RELEASE: win_sel = cfg.release_window;
			PH_QUIET1:  win_sel = cfg.first_quiet_window;
			PH_QUIET2:  win_sel = cfg.final_quiet_window;
			PH_BURST1,
			PH_BURST2:  win_sel = (pd_q == '0) ? cfg.first_press_window
			                                   : cfg.next_press_window;
			default:    win_sel = cfg.release_window;
		endcase
	end

	assign win_lim = (win_sel == '0) ? WIN_W'(1) : win_sel;
	assign expired = CMP_W'(wt_inc) >= CMP_W'(win_lim);

	assign need       = (phase_q == PH_BURST2) ? cfg.second_burst_presses
	                                           : cfg.first_burst_presses;
	assign need_lim   = (need == '0) ? PRESS_W'(1) : need;
	assign burst_done = (CNT_CMP_W'(pd_q) + CNT_CMP_W'(1)) >= CNT_CMP_W'(need_lim);
	assign match      = wfr_q ? ~pressed : pressed;

	always_comb begin
		logic fail;
		logic enter;
		phase_t ph_next;

		fail     = 1'b0;
		enter    = 1'b0;
		ph_next  = phase_q;
		phase_d  = phase_q;
		wfr_d    = wfr_q;
		pd_d     = pd_q;
		wt_d     = wt_q;
		status   = ST_RUN;
		progress = PROG_NONE;

		if (start_req) begin
			enter = 1'b1;
			if (pressed) begin
				ph_next  = PH_RELEASE;
				progress = PROG_ONE;
			end else begin
				ph_next = PH_IDLE;
				status  = ST_NOARM;
			end
		end else begin
			unique case (phase_q)
				PH_RELEASE: begin
					progress = PROG_ONE;
					if (!pressed) begin
						enter   = 1'b1;
						ph_next = PH_BURST1;
					end else begin
						wt_d = wt_inc;
						fail = expired;
					end
				end
				PH_BURST1, PH_BURST2: begin
					progress = (phase_q == PH_BURST1) ? PROG_ONE : PROG_TWO;
					if (!match) begin
						wt_d = wt_inc;
						fail = expired;
					end else begin
						wt_d = '0;
						if (!wfr_q) begin
							wfr_d = 1'b1;
						end else begin
							wfr_d = 1'b0;
							if (burst_done) begin
								enter   = 1'b1;
								ph_next = (phase_q == PH_BURST1) ? PH_QUIET1 : PH_QUIET2;
							end else if (pd_q != {COUNT_BITS{1'b1}}) begin
								pd_d = pd_q + 1'b1;
							end
						end
					end
				end
				PH_QUIET1: begin
					progress = PROG_ONE;
					if (pressed) begin
						fail = 1'b1;
					end else begin
						wt_d = wt_inc;
						if (expired) begin
							enter    = 1'b1;
							ph_next  = PH_BURST2;
							progress = PROG_TWO;
						end
					end
				end
				PH_QUIET2: begin
					progress = PROG_TWO;
					if (pressed) begin
						fail = 1'b1;
					end else begin
						wt_d = wt_inc;
						if (expired) begin
							status  = ST_PASS;
							enter   = 1'b1;
							ph_next = PH_IDLE;
						end
					end
				end
				default: begin
					enter   = 1'b1;
					ph_next = PH_IDLE;
				end
			endcase
			if (fail) begin
				status   = ST_FAIL;
				progress = PROG_NONE;
				enter    = 1'b1;
				ph_next  = PH_IDLE;
			end
		end

		if (enter) begin
			phase_d = ph_next;
			wfr_d   = 1'b0;
			pd_d    = '0;
			wt_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wfr_q   <= 1'b0;
			pd_q    <= '0;
			wt_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			wfr_q   <= wfr_d;
			pd_q    <= pd_d;
			wt_q    <= wt_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register lost its one-hot code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (wt_q == '0 && pd_q == '0 && !wfr_q))
		else $error("idle phase holds stale wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RELEASE || phase_q == PH_QUIET1 || phase_q == PH_QUIET2)
		|-> (pd_q == '0 && !wfr_q))
		else $error("press state set outside a burst");

endmodule

`default_nettype wire

[rtl/core/button_press_sequence_detector.sv]
// Top level of the button press sequence detector: stream ports, stages, config.
// Path: a sample taken in is held in the input stage, then its result is registered in the
// result stage and offered on the master side, where it transfers when not stalled.
// Throughput: one sample per cycle while the master side is not stalled; the one-tick
// sequence update sits between the input stage and the result stage.
// Reset (arst_n low, asynchronous): both stages empty, sequencer idle, registers at defaults.
`default_nettype none

module button_press_sequence_detector #(
	parameter int unsigned TIMER_BITS = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input samples
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [7:0]                        s_axis_tdata,  // [0] start_req, [1] button_level
	// Results
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [7:0]                             m_axis_tdata,  // [1:0] status, [3:2] progress
	// Register writes
	input  wire logic                              cfg_we,
	input  wire logic [bpsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bpsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bpsd_pkg::*;

	cfg_t       cfg;

	// Input stage
	logic       valid_s1;
	logic       start_req_s1;
	logic       button_level_s1;

	// Result stage
	logic       valid_s2;
	status_t    status_s2;
	logic [1:0] progress_s2;

	status_t    seq_status;
	logic [1:0] seq_progress;
	logic       s1_load;
	logic       s2_load;

	bpsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the sequencer exactly when the held sample moves into the result stage
	bpsd_seq #(
		.TIMER_BITS (TIMER_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (s2_load),
		.start_req    (start_req_s1),
		.button_level (button_level_s1),
		.cfg          (cfg),
		.status       (seq_status),
		.progress     (seq_progress)
	);

	// Result stage takes a sample when it is empty or its result is being transferred
	assign s2_load       = valid_s1 && (!valid_s2 || m_axis_tready);
	// Input stage frees up in the same cycle that it hands over
	assign s_axis_tready = !valid_s1 || s2_load;
	assign s1_load       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Hold the sample until the result stage takes it
	always_ff @(posedge clk) begin
		if (s1_load) begin
			start_req_s1    <= s_axis_tdata[0];
			button_level_s1 <= s_axis_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			status_s2   <= seq_status;
			progress_s2 <= seq_progress;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, progress_s2, logic'(status_s2[1]), logic'(status_s2[0])};

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_s2 == ST_PASS) |-> (progress_s2 == PROG_TWO))
		else $error("pass reported without both stars");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (status_s2 == ST_FAIL || status_s2 == ST_NOARM))
		|-> (progress_s2 == PROG_NONE))
		else $error("stars left standing on fail or no-arm");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (progress_s2 == PROG_NONE || progress_s2 == PROG_ONE ||
		                   progress_s2 == PROG_TWO))
		else $error("progress out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled while the pipeline could move");

	assert property (@(posedge clk) disable iff (!arst_n)
		s2_load |=> valid_s2)
		else $error("result stage dropped a loaded result");

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the button press sequence detector: directed and random samples.
`default_nettype none

import bpsd_pkg::*;

localparam int TIMER_BITS = 16;
localparam int COUNT_BITS = 8;

typedef struct packed {
	logic [1:0] progress;
	status_t    status;
} verdict_t;

typedef enum int {BURST_BUSY, BURST_DONE, BURST_BROKEN} burst_t;

// Tracks the detector tick by tick and holds the verdicts still owed by the block.
class sequence_checker;
	cfg_t                    regs;
	phase_t                  phase;
	bit                      wait_release;
	logic [COUNT_BITS-1:0]   presses;
	logic [TIMER_BITS-1:0]   ticks;
	verdict_t                expected_verdicts[$];
	int                      errors, n_samples, n_pass, n_fail, n_refused;

	function new();
		regs = cfg_t'{RST_FIRST_BURST, RST_SECOND_BURST, RST_RELEASE_WIN, RST_FIRST_PRESS,
			RST_NEXT_PRESS, RST_FIRST_QUIET, RST_FINAL_QUIET};
		enter(PH_IDLE);
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_FIRST_BURST:  regs.first_burst_presses  = data[PRESS_W-1:0];
			CFG_SECOND_BURST: regs.second_burst_presses = data[PRESS_W-1:0];
			CFG_RELEASE_WIN:  regs.release_window       = data;
			CFG_FIRST_PRESS:  regs.first_press_window   = data;
			CFG_NEXT_PRESS:   regs.next_press_window    = data;
			CFG_FIRST_QUIET:  regs.first_quiet_window   = data;
			CFG_FINAL_QUIET:  regs.final_quiet_window   = data;
			default: ;
		endcase
	endfunction

	function void enter(phase_t p);
		phase = p;
		wait_release = 1'b0;
		presses = '0;
		ticks = '0;
	endfunction

	// Count one unmatched sample; true once the window is used up.
	function bit window_used(logic [WIN_W-1:0] win);
		logic [WIN_W-1:0] lim;
		lim = (win == '0) ? WIN_W'(1) : win;
		if (ticks != '1)
			ticks++;
		return ticks >= lim;
	endfunction

	function burst_t burst_step(bit pressed, logic [PRESS_W-1:0] need);
		logic [PRESS_W-1:0] n;
		logic [WIN_W-1:0]   win;
		n = (need == '0) ? PRESS_W'(1) : need;
		win = (presses == 0) ? regs.first_press_window : regs.next_press_window;
		// waiting for a press matches a pressed sample, waiting for a release a released one
		if (pressed == wait_release)
			return window_used(win) ? BURST_BROKEN : BURST_BUSY;
		ticks = '0;
		if (!wait_release) begin
			wait_release = 1'b1;
			return BURST_BUSY;
		end
		wait_release = 1'b0;
		if (presses + 1 >= n)
			return BURST_DONE;
		if (presses != '1)
			presses++;
		return BURST_BUSY;
	endfunction

	// Advance one poll tick and queue the verdict the block owes for it.
	function void take_sample(bit start, bit level);
		verdict_t v;
		bit       pressed;
		burst_t   r;
		pressed = !level;
		v.status = ST_RUN;
		v.progress = PROG_NONE;
		if (start) begin
			if (pressed) begin
				enter(PH_RELEASE);
				v.progress = PROG_ONE;
			end else begin
				enter(PH_IDLE);
				v.status = ST_NOARM;
			end
		end else begin
			case (phase)
				PH_RELEASE: begin
					v.progress = PROG_ONE;
					if (!pressed)
						enter(PH_BURST1);
					else if (window_used(regs.release_window))
						v.status = ST_FAIL;
				end
				PH_BURST1: begin
					v.progress = PROG_ONE;
					r = burst_step(pressed, regs.first_burst_presses);
					if (r == BURST_DONE)
						enter(PH_QUIET1);
					else if (r == BURST_BROKEN)
						v.status = ST_FAIL;
				end
				PH_QUIET1: begin
					v.progress = PROG_ONE;
					if (pressed)
						v.status = ST_FAIL;
					else if (window_used(regs.first_quiet_window)) begin
						enter(PH_BURST2);
						v.progress = PROG_TWO;
					end
				end
				PH_BURST2: begin
					v.progress = PROG_TWO;
					r = burst_step(pressed, regs.second_burst_presses);
					if (r == BURST_DONE)
						enter(PH_QUIET2);
					else if (r == BURST_BROKEN)
						v.status = ST_FAIL;
				end
				PH_QUIET2: begin
					v.progress = PROG_TWO;
					if (pressed)
						v.status = ST_FAIL;
					else if (window_used(regs.final_quiet_window)) begin
						v.status = ST_PASS;
						enter(PH_IDLE);
					end
				end
				default: enter(PH_IDLE);
			endcase
			if (v.status == ST_FAIL) begin
				v.progress = PROG_NONE;
				enter(PH_IDLE);
			end
		end
		n_samples++;
		if (v.status == ST_PASS)
			n_pass++;
		else if (v.status == ST_FAIL)
			n_fail++;
		else if (v.status == ST_NOARM)
			n_refused++;
		expected_verdicts.push_back(v);
	endfunction

	function void check_verdict(logic [7:0] data);
		verdict_t v;
		if (expected_verdicts.size() == 0) begin
			$display("%0t: result %h arrived with none expected", $time, data);
			errors++;
			return;
		end
		v = expected_verdicts.pop_front();
		if (data[1:0] !== v.status) begin
			$display("%0t: status expected %0d, got %0d", $time, v.status, data[1:0]);
			errors++;
		end
		if (data[3:2] !== v.progress) begin
			$display("%0t: progress expected %0d, got %0d", $time, v.progress, data[3:2]);
			errors++;
		end
		if (data[7:4] !== 4'h0) begin
			$display("%0t: padding expected 0, got %h", $time, data[7:4]);
			errors++;
		end
	endfunction

	function int pending();
		return expected_verdicts.size();
	endfunction
endclass

module testbench;
	// Cycle budget: about 1200 samples under the heaviest idling, plus the drains
	// between settings, taken many times over.
	localparam int LIMIT = 100000;
	// Extra clock edges waited after the last owed result has come back.
	localparam int TAIL = 10;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_SAMPLES = 40;

	// Index beyond the register list; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	// Letters of the directed script.
	localparam byte SCR_ARM    = "S";  // start with the button held
	localparam byte SCR_REFUSE = "s";  // start with the button up
	localparam byte SCR_PRESS  = "p";
	localparam byte SCR_LIFT   = "r";

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {SET_SMALL, SET_LOW, SET_HIGH, SET_MEDIUM} setting_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;   // [0] start_req, [1] button_level
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;   // [1:0] status, [3:2] progress
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sequence_checker sb;
	int              idle_pct, stall_pct;
	int              cycles, n_sent, n_settings;
	int              left;   // samples still allowed in the current sequence
	bit              dirty;  // current sequence carries noise and overruns

	button_press_sequence_detector #(
		.TIMER_BITS(TIMER_BITS),
		.COUNT_BITS(COUNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver side: drop tready at random, at the rate of the current idle mode.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watch both sides: every input transfer feeds the predictor, every result
	// transfer is checked against the oldest verdict. Also guard the run time.
	always @(posedge clk) begin
		cycles++;
		if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
			sb.take_sample(s_axis_tdata[0], s_axis_tdata[1]);
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			sb.check_verdict(m_axis_tdata);
		if (cycles > LIMIT) begin
			$display("%0t: run exceeded %0d cycles with %0d results outstanding",
				$time, LIMIT, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic set_mode(idle_mode_t m);
		case (m)
			IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin idle_pct = 45; stall_pct = 0;  end
			IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 45; end
			default:       begin idle_pct = 16; stall_pct = 16; end
		endcase
	endtask

	// Offer one sample and hold it until the transfer happens.
	task automatic send_sample(bit start, bit level);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, level, start};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		n_sent++;
	endtask

	// Hold the sender off until every owed verdict has come back.
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	// Write one register; the write enable stays up for back-to-back writes.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Write every register; the press counts get junk in the unused upper byte.
	task automatic apply_setting(cfg_t c);
		write_reg(CFG_UNUSED, 16'($urandom));
		write_reg(CFG_FIRST_BURST, {8'($urandom), c.first_burst_presses});
		write_reg(CFG_SECOND_BURST, {8'($urandom), c.second_burst_presses});
		write_reg(CFG_RELEASE_WIN, c.release_window);
		write_reg(CFG_FIRST_PRESS, c.first_press_window);
		write_reg(CFG_NEXT_PRESS, c.next_press_window);
		write_reg(CFG_FIRST_QUIET, c.first_quiet_window);
		write_reg(CFG_FINAL_QUIET, c.final_quiet_window);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_script(string script);
		for (int i = 0; i < script.len(); i++) begin
			case (script[i])
				SCR_ARM:    send_sample(1'b1, 1'b0);
				SCR_REFUSE: send_sample(1'b1, 1'b1);
				SCR_PRESS:  send_sample(1'b0, 1'b0);
				default:    send_sample(1'b0, 1'b1);
			endcase
		end
	endtask

	function automatic int eff(int v);
		return (v == 0) ? 1 : v;
	endfunction

	// Unmatched samples before the edge: mostly short, sometimes right at the
	// window limit, and in noisy sequences sometimes past it.
	function automatic int pick_delay(int win);
		int w;
		w = eff(win);
		if (dirty && $urandom_range(99) < 8)
			return w + $urandom_range(1);
		if (w <= 16 && $urandom_range(9) == 0)
			return w - 1;
		return $urandom_range((w - 1 < 4) ? w - 1 : 4);
	endfunction

	function automatic logic [15:0] rand_field(int hi);
		return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(hi, 1));
	endfunction

	function automatic cfg_t pick_setting(setting_t kind);
		cfg_t c;
		int   pmax, wmax;
		if (kind == SET_HIGH)
			return '1;
		pmax = (kind == SET_LOW) ? 1 : 4;
		wmax = (kind == SET_LOW) ? 1 : (kind == SET_SMALL) ? 8 : 20;
		c.first_burst_presses = 8'(rand_field(pmax));
		c.second_burst_presses = 8'(rand_field(pmax));
		c.release_window = rand_field(wmax);
		c.first_press_window = rand_field(wmax);
		c.next_press_window = rand_field(wmax);
		c.first_quiet_window = rand_field(wmax);
		c.final_quiet_window = rand_field(wmax);
		return c;
	endfunction

	// Emit one sample of a sequence; noisy sequences flip the level or slip in a start.
	task automatic put(bit start, bit level);
		int r;
		if (left == 0)
			return;
		if (dirty) begin
			r = $urandom_range(99);
			if (r < 3)
				level = ~level;
			else if (r == 3)
				start = 1'b1;
		end
		send_sample(start, level);
		left--;
	endtask

	task automatic run_burst(int need, int win_first, int win_next);
		int w;
		for (int k = 0; k < eff(need) && left != 0; k++) begin
			w = (k == 0) ? win_first : win_next;
			repeat (pick_delay(w)) put(1'b0, 1'b1);
			put(1'b0, 1'b0);
			repeat (pick_delay(w)) put(1'b0, 1'b0);
			put(1'b0, 1'b1);
		end
	endtask

	// One recovery attempt shaped on the current setting. A sequence longer than
	// cap is cut short and the next one restarts the running detection.
	task automatic run_sequence(cfg_t c, int cap, bit may_be_dirty);
		left = cap;
		dirty = may_be_dirty && ($urandom_range(9) < 3);
		put(1'b1, 1'b0);
		repeat (pick_delay(c.release_window)) put(1'b0, 1'b0);
		put(1'b0, 1'b1);
		run_burst(c.first_burst_presses, c.first_press_window, c.next_press_window);
		// Now and then stall the sender mid-detection until the output drains.
		if (left != 0 && $urandom_range(7) == 0)
			wait_results();
		repeat (eff(c.first_quiet_window)) put(1'b0, 1'b1);
		run_burst(c.second_burst_presses, c.first_press_window, c.next_press_window);
		repeat (eff(c.final_quiet_window)) put(1'b0, 1'b1);
		repeat ($urandom_range(3)) put(1'b0, 1'($urandom_range(1)));
	endtask

	initial begin
		cfg_t     c;
		setting_t kind;
		int       target;
		sb = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		set_mode(IDLE_NONE);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: idle samples both ways, refused start, arm, restart
		// while running, then a clean full pass at the reset timing.
		run_script("rpsSSprp");
		run_sequence(cfg_t'{RST_FIRST_BURST, RST_SECOND_BURST, RST_RELEASE_WIN,
			RST_FIRST_PRESS, RST_NEXT_PRESS, RST_FIRST_QUIET, RST_FINAL_QUIET}, 600, 1'b0);
		wait_results();

		// All registers zero, so every count and window acts as one: a full pass,
		// a missed press, a press in the quiet gap, a held button at release.
		apply_setting('0);
		run_script("SrprrprrSrrSrprpSp");

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_mode(idle_mode_t'(p % 4));
			wait_results();
			kind = setting_t'((p + p / 4) % 4);
			c = pick_setting(kind);
			apply_setting(c);
			target = n_sent + PHASE_SAMPLES;
			while (n_sent < target)
				run_sequence(c, (kind == SET_HIGH) ? 60 : 300, 1'b1);
		end
		wait_results();

		if (sb.pending() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending());
		$display("Ran %0d samples under %0d register settings and four idle patterns",
			sb.n_samples, n_settings);
		$display("Detections passed %0d, failed %0d, start refused %0d",
			sb.n_pass, sb.n_fail, sb.n_refused);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

`default_nettype wire

[button_press_sequence_detector.f]
rtl/core/bpsd_pkg.sv
rtl/core/bpsd_cfg_regs.sv
rtl/core/bpsd_seq.sv
rtl/core/button_press_sequence_detector.sv
test/testbench.sv
